// File: rtl/cts_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the Cauchy transform solver.
// No dependencies; used by cts_dp, cts_ctrl and the top level.
package cts_pkg;

  localparam int VALUE_W    = 32;
  localparam int FRAC_BITS  = 16;
  localparam int MAX_ORDER  = 16;
  localparam int ORDER_W    = 5;
  localparam int ITER_W     = 8;
  localparam int TOL_W      = 31;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 31;

  localparam logic [CFG_IDX_W-1:0] CFG_ORDER    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_ITER = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_TOL      = 2'd2;

  localparam logic [ORDER_W-1:0] ORDER_RST = 5'd16;
  localparam logic [ITER_W-1:0]  ITER_RST  = 8'd64;
  localparam logic [TOL_W-1:0]   TOL_RST   = 31'd66;

  localparam logic [1:0] CMD_LOAD  = 2'd0;
  localparam logic [1:0] CMD_EVAL  = 2'd1;
  localparam logic [1:0] CMD_SOLVE = 2'd2;

  typedef struct packed {
    logic [1:0]                command;
    logic [3:0]                coeff_index;
    logic signed [VALUE_W-1:0] operand;
  } cts_in_t;

  typedef struct packed {
    logic signed [VALUE_W-1:0] answer;
    logic [ITER_W-1:0]         iterations_used;
    logic                      converged;
    logic                      divide_error;
  } cts_out_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic capture;
    logic load;
    logic pinit;
    logic xsel_w;
    logic pm1;
    logic pm2;
    logic subd;
    logic div_start;
    logic div_sel_d;
    logic div_step;
    logic w_recip;
    logic conv_en;
    logic set_err;
    logic it_inc;
    logic out_load;
    logic out_eval;
  } cts_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic z_zero;
    logic n_zero;
    logic poly_last;
    logic d_zero;
    logic div_last;
    logic conv;
    logic it_limit;
  } cts_sts_t;

endpackage

// File: rtl/cts_ram.sv
`timescale 1ns / 1ps
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module cts_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// File: rtl/cts_dp.sv
`timescale 1ns / 1ps
// Datapath of the solver: configuration registers, coefficient RAM, shared
// multiplier, polynomial accumulator, serial divider and result register.
// Depends on cts_pkg and cts_ram.
module cts_dp #(
  parameter int MAX_ORDER = cts_pkg::MAX_ORDER
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [cts_pkg::CFG_IDX_W-1:0]    cfg_idx_i,
  input  logic [cts_pkg::CFG_DATA_W-1:0]   cfg_data_i,
  input  cts_pkg::cts_in_t                 in_data_i,
  input  cts_pkg::cts_cmd_t                cmd_i,
  output cts_pkg::cts_sts_t                sts_o,
  output cts_pkg::cts_out_t                out_data_o
);

  localparam int VW  = cts_pkg::VALUE_W;
  localparam int F   = cts_pkg::FRAC_BITS;
  localparam int SW  = 2 * VW + 2;
  localparam int QW  = 2 * F + 1;
  localparam int DCW = $clog2(QW);
  localparam int AW  = (MAX_ORDER > 1) ? $clog2(MAX_ORDER) : 1;
  localparam int CW  = $clog2(MAX_ORDER + 1);
  localparam int NW  = cts_pkg::ORDER_W + CW;
  localparam logic signed [SW-1:0] VMAX_S = {{(SW - VW + 1){1'b0}}, {(VW - 1){1'b1}}};
  localparam logic signed [SW-1:0] VMIN_S = ~VMAX_S;
  localparam logic signed [VW-1:0] VMAX_V = {1'b0, {(VW - 1){1'b1}}};
  localparam logic signed [VW-1:0] ONE_Q  = VW'(1) << F;
  localparam logic [DCW-1:0]       ONE_POS = DCW'(2 * F);

  function automatic logic signed [VW-1:0] sat_v(input logic signed [SW-1:0] v);
    logic signed [VW-1:0] r;
    if (v > VMAX_S) r = VMAX_S[VW-1:0];
    else if (v < VMIN_S) r = VMIN_S[VW-1:0];
    else r = v[VW-1:0];
    return r;
  endfunction

  // Configuration registers.
  logic [cts_pkg::ORDER_W-1:0] order_q;
  logic [cts_pkg::ITER_W-1:0]  maxit_q;
  logic [cts_pkg::TOL_W-1:0]   tol_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      order_q <= cts_pkg::ORDER_RST;
      maxit_q <= cts_pkg::ITER_RST;
      tol_q   <= cts_pkg::TOL_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        cts_pkg::CFG_ORDER:    order_q <= cfg_data_i[cts_pkg::ORDER_W-1:0];
        cts_pkg::CFG_MAX_ITER: maxit_q <= cfg_data_i[cts_pkg::ITER_W-1:0];
        cts_pkg::CFG_TOL:      tol_q   <= cfg_data_i[cts_pkg::TOL_W-1:0];
        default: ;
      endcase
    end
  end

  // Coefficient store.
  logic [AW+3:0]          widx;
  logic                   ram_we;
  logic [CW-1:0]          i_q;
  logic [VW-1:0]          coef_rd;

  assign widx   = {{AW{1'b0}}, in_data_i.coeff_index};
  assign ram_we = cmd_i.load && (widx < (AW + 4)'(MAX_ORDER));

  cts_ram #(
    .WIDTH(VW),
    .DEPTH(MAX_ORDER)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(widx[AW-1:0]),
    .wdata_i(in_data_i.operand),
    .raddr_i(i_q[AW-1:0]),
    .rdata_o(coef_rd)
  );

  // Shared multiplier with round-half-up and saturation.
  logic signed [VW-1:0]   z_q, x_q, w_q, d_q, acc_q, pw_q, prod_q;
  logic signed [VW-1:0]   ma, mb, qm;
  logic signed [2*VW-1:0] mul;
  logic signed [2*VW:0]   prnd;

  assign ma   = cmd_i.pm1 ? $signed(coef_rd) : pw_q;
  assign mb   = cmd_i.pm1 ? pw_q : x_q;
  assign mul  = ma * mb;
  assign prnd = {mul[2*VW-1], mul} + (2 * VW + 1)'(1 << (F - 1));
  assign qm   = sat_v(SW'(prnd >>> F));

  logic [NW-1:0] n_eff, ord_ext;
  assign ord_ext = NW'(order_q);
  assign n_eff   = (ord_ext > NW'(MAX_ORDER)) ? NW'(MAX_ORDER) : ord_ext;

  // Serial restoring divider for 2^(2F) / |d|.
  logic [VW-1:0]   dv_q;
  logic [VW:0]     rem_q, rem_sh;
  logic [QW-1:0]   quo_q;
  logic [DCW-1:0]  cnt_q;
  logic            neg_q;
  logic signed [VW-1:0] dsrc, recip;
  logic signed [SW-1:0] qext;
  logic signed [VW:0]   diff;
  logic [VW:0]          adiff;
  logic                 close;

  assign dsrc   = cmd_i.div_sel_d ? d_q : z_q;
  assign rem_sh = {rem_q[VW-1:0], cnt_q == ONE_POS};
  assign qext   = neg_q ? -SW'(quo_q) : SW'(quo_q);
  assign recip  = sat_v(qext);
  assign diff   = {recip[VW-1], recip} - {w_q[VW-1], w_q};
  assign adiff  = diff[VW] ? (VW + 1)'(-diff) : diff;
  assign close  = adiff < (VW + 1)'(tol_q);

  logic [cts_pkg::ITER_W-1:0] it_q;
  logic conv_q, err_q;
  cts_pkg::cts_out_t out_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      z_q    <= in_data_i.operand;
      it_q   <= '0;
      conv_q <= 1'b0;
      err_q  <= 1'b0;
    end
    if (cmd_i.pinit) begin
      acc_q <= '0;
      pw_q  <= ONE_Q;
      i_q   <= '0;
      x_q   <= cmd_i.xsel_w ? w_q : z_q;
    end
    if (cmd_i.pm1) begin
      prod_q <= qm;
    end
    if (cmd_i.pm2) begin
      acc_q <= sat_v(SW'(acc_q) + SW'(prod_q));
      pw_q  <= qm;
      i_q   <= i_q + CW'(1);
    end
    if (cmd_i.subd) begin
      d_q <= sat_v(SW'(z_q) - SW'(acc_q));
    end
    if (cmd_i.div_start) begin
      dv_q  <= dsrc[VW-1] ? VW'(-dsrc) : dsrc;
      neg_q <= dsrc[VW-1];
      rem_q <= '0;
      quo_q <= '0;
      cnt_q <= DCW'(QW - 1);
    end
    if (cmd_i.div_step) begin
      if (rem_sh >= {1'b0, dv_q}) begin
        rem_q <= rem_sh - {1'b0, dv_q};
        quo_q <= {quo_q[QW-2:0], 1'b1};
      end else begin
        rem_q <= rem_sh;
        quo_q <= {quo_q[QW-2:0], 1'b0};
      end
      cnt_q <= cnt_q - DCW'(1);
    end
    if (cmd_i.w_recip) begin
      w_q <= recip;
      if (cmd_i.conv_en) begin
        conv_q <= close;
      end
    end
    if (cmd_i.set_err) begin
      w_q   <= VMAX_V;
      err_q <= 1'b1;
    end
    if (cmd_i.it_inc) begin
      it_q <= it_q + cts_pkg::ITER_W'(1);
    end
    if (cmd_i.out_load) begin
      if (cmd_i.out_eval) begin
        out_q.answer          <= acc_q;
        out_q.iterations_used <= '0;
        out_q.converged       <= 1'b0;
        out_q.divide_error    <= 1'b0;
      end else begin
        out_q.answer          <= w_q;
        out_q.iterations_used <= it_q;
        out_q.converged       <= conv_q;
        out_q.divide_error    <= err_q;
      end
    end
  end

  assign sts_o.z_zero    = (z_q == '0);
  assign sts_o.n_zero    = (n_eff == '0);
  assign sts_o.poly_last = (NW'(i_q) + NW'(1) == n_eff);
  assign sts_o.d_zero    = (d_q == '0);
  assign sts_o.div_last  = (cnt_q == '0);
  assign sts_o.conv      = conv_q;
  assign sts_o.it_limit  = (it_q == maxit_q);
  assign out_data_o      = out_q;

endmodule

// File: rtl/cts_ctrl.sv
`timescale 1ns / 1ps
// Controller state machine of the solver: sequences load, evaluate and solve
// requests over the datapath. Depends on cts_pkg.
module cts_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  input  logic [1:0]        in_command_i,
  output logic              in_stall_o,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  input  cts_pkg::cts_sts_t sts_i,
  output cts_pkg::cts_cmd_t cmd_o
);

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_PINIT = 4'd1;
  localparam logic [3:0] S_PA    = 4'd2;
  localparam logic [3:0] S_PM1   = 4'd3;
  localparam logic [3:0] S_PM2   = 4'd4;
  localparam logic [3:0] S_SUBD  = 4'd5;
  localparam logic [3:0] S_DCHK  = 4'd6;
  localparam logic [3:0] S_ZCHK  = 4'd7;
  localparam logic [3:0] S_DIV   = 4'd8;
  localparam logic [3:0] S_UPD   = 4'd9;
  localparam logic [3:0] S_CHECK = 4'd10;
  localparam logic [3:0] S_EMIT  = 4'd11;
  localparam logic [3:0] S_OUT   = 4'd12;

  logic [3:0] state_q, state_d;
  logic       solve_q, solve_d;
  logic       first_q, first_d;
  logic       accept;

  assign in_stall_o  = (state_q != S_IDLE);
  assign out_valid_o = (state_q == S_OUT);
  assign accept      = in_valid_i && !in_stall_o;

  always_comb begin
    state_d = state_q;
    solve_d = solve_q;
    first_d = first_q;
    cmd_o   = '0;
    cmd_o.xsel_w   = solve_q;
    cmd_o.out_eval = !solve_q;
    case (state_q)
      S_IDLE: begin
        if (accept) begin
          case (in_command_i)
            cts_pkg::CMD_LOAD: cmd_o.load = 1'b1;
            cts_pkg::CMD_EVAL: begin
              cmd_o.capture = 1'b1;
              solve_d = 1'b0;
              state_d = S_PINIT;
            end
            cts_pkg::CMD_SOLVE: begin
              cmd_o.capture = 1'b1;
              solve_d = 1'b1;
              state_d = S_ZCHK;
            end
            default: ;
          endcase
        end
      end
      S_PINIT: begin
        cmd_o.pinit = 1'b1;
        state_d = S_PA;
      end
      S_PA: begin
        // The coefficient read is issued here; data is valid next cycle.
        if (sts_i.n_zero) begin
          state_d = solve_q ? S_SUBD : S_EMIT;
        end else begin
          state_d = S_PM1;
        end
      end
      S_PM1: begin
        cmd_o.pm1 = 1'b1;
        state_d = S_PM2;
      end
      S_PM2: begin
        cmd_o.pm2 = 1'b1;
        if (sts_i.poly_last) begin
          state_d = solve_q ? S_SUBD : S_EMIT;
        end else begin
          state_d = S_PA;
        end
      end
      S_SUBD: begin
        cmd_o.subd = 1'b1;
        state_d = S_DCHK;
      end
      S_DCHK: begin
        if (sts_i.d_zero) begin
          cmd_o.set_err = 1'b1;
          state_d = S_EMIT;
        end else begin
          cmd_o.div_start = 1'b1;
          cmd_o.div_sel_d = 1'b1;
          state_d = S_DIV;
        end
      end
      S_ZCHK: begin
        if (sts_i.z_zero) begin
          cmd_o.set_err = 1'b1;
          state_d = S_EMIT;
        end else begin
          cmd_o.div_start = 1'b1;
          first_d = 1'b1;
          state_d = S_DIV;
        end
      end
      S_DIV: begin
        cmd_o.div_step = 1'b1;
        if (sts_i.div_last) begin
          state_d = S_UPD;
        end
      end
      S_UPD: begin
        // The starting reciprocal is not tested against the tolerance.
        cmd_o.w_recip = 1'b1;
        cmd_o.conv_en = !first_q;
        first_d = 1'b0;
        state_d = S_CHECK;
      end
      S_CHECK: begin
        if (sts_i.conv || sts_i.it_limit) begin
          state_d = S_EMIT;
        end else begin
          cmd_o.it_inc = 1'b1;
          state_d = S_PINIT;
        end
      end
      S_EMIT: begin
        cmd_o.out_load = 1'b1;
        state_d = S_OUT;
      end
      S_OUT: begin
        if (!out_stall_i) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      solve_q <= 1'b0;
      first_q <= 1'b0;
    end else begin
      state_q <= state_d;
      solve_q <= solve_d;
      first_q <= first_d;
    end
  end

endmodule

// File: rtl/cauchy_transform_fixed_point_solver.sv
`timescale 1ns / 1ps
// Cauchy transform solver over a table of cumulant coefficients, Q16.16.
// Top level: joins cts_ctrl and cts_dp. Depends on cts_pkg.
//
// Usage: requests enter on in_valid_i/in_stall_o with payload in_data_i.
// A load request writes one coefficient and gives no result.
// An evaluate request returns R(z) over order_in_use coefficients.
// A solve request iterates w = 1/(z - R(w)) from w = 1/z and returns w, the
// iteration count and the converged and divide-error flags. Command 3 is
// dropped. Results leave on out_valid_o/out_stall_i with payload out_data_o.
// Only one request is in flight; in_stall_o is high until its result has
// been taken. A stalled result holds its payload until taken.
// An evaluate walks the polynomial one term at a time on the shared
// multiplier, through states S_PA, S_PM1 and S_PM2. A solve first forms the
// starting reciprocal of z on the 33-step serial divider; each iteration
// then walks the polynomial in w, forms d = z - R(w) and divides again.
// Configuration writes take effect in the next cycle.
// Reset clears the controller and loads the register defaults; the
// coefficient RAM holds no defined value until written.
module cauchy_transform_fixed_point_solver #(
  parameter int MAX_ORDER = cts_pkg::MAX_ORDER
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  cts_pkg::cts_in_t               in_data_i,
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output cts_pkg::cts_out_t              out_data_o,
  input  logic                           cfg_we_i,
  input  logic [cts_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [cts_pkg::CFG_DATA_W-1:0] cfg_data_i
);

  cts_pkg::cts_cmd_t cmd;
  cts_pkg::cts_sts_t sts;

  cts_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_command_i(in_data_i.command),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  cts_dp #(
    .MAX_ORDER(MAX_ORDER)
  ) u_dp (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cfg_we_i  (cfg_we_i),
    .cfg_idx_i (cfg_idx_i),
    .cfg_data_i(cfg_data_i),
    .in_data_i (in_data_i),
    .cmd_i     (cmd),
    .sts_o     (sts),
    .out_data_o(out_data_o)
  );

endmodule
